// ===== rtl/pacl_pkg.sv =====
// ============================================================================
// pacl_pkg - shared types and constants of the prefix access list filter
// field widths, request and decision codes, table entry layout and the
// command and status bundles between controller and datapath
// ============================================================================
`default_nettype none

package pacl_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int TYPE_W     = 2;
    localparam int FAM_W      = 2;
    localparam int ADDR_W     = 64;
    localparam int PLEN_W     = 8;
    localparam int DEC_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_CLEAR      = 2'd0,
        REQ_ADD_ACCEPT = 2'd1,
        REQ_ADD_REJECT = 2'd2,
        REQ_CHECK      = 2'd3
    } req_type_t;

    localparam logic [FAM_W-1:0] FAM_IPV4  = 2'd0;
    localparam logic [FAM_W-1:0] FAM_IPV6  = 2'd1;
    localparam logic [FAM_W-1:0] FAM_MAC48 = 2'd2;
    localparam logic [FAM_W-1:0] FAM_EUI64 = 2'd3;

    localparam logic [DEC_W-1:0] DEC_DEFAULT = 2'd0;
    localparam logic [DEC_W-1:0] DEC_REJECT  = 2'd1;
    localparam logic [DEC_W-1:0] DEC_ACCEPT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ORDER   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DFLT_VERDICT = 1'b1;

    typedef enum logic {
        TBL_ACCEPT = 1'b0,
        TBL_REJECT = 1'b1
    } tbl_t;

    // one stored prefix, length already saturated to the family width
    typedef struct packed {
        logic [FAM_W-1:0]  fam;
        logic [PLEN_W-1:0] plen;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic write;
        tbl_t write_tbl;
        logic scan_start;
        logic scan_step;
        tbl_t scan_tbl;
    } cmd_t;

    typedef struct packed {
        logic accept_full;
        logic reject_full;
        logic hit;
        logic done;
    } stat_t;

    function automatic logic [PLEN_W-1:0] family_width(input logic [FAM_W-1:0] fam);
        logic [PLEN_W-1:0] w;
        unique case (fam)
            FAM_IPV4:  w = 8'd32;
            FAM_IPV6:  w = 8'd128;
            FAM_MAC48: w = 8'd48;
            FAM_EUI64: w = 8'd64;
        endcase
        return w;
    endfunction

    function automatic logic [PLEN_W-1:0] sat_plen(input logic [FAM_W-1:0]  fam,
                                                   input logic [PLEN_W-1:0] plen);
        logic [PLEN_W-1:0] w;
        w = family_width(fam);
        return (plen > w) ? w : plen;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pacl_if.sv =====
// ============================================================================
// pacl_if - request and response channels of the prefix access list filter
// valid/ready handshake with the payload fields carried alongside
// ============================================================================
`default_nettype none

interface pacl_req_if
    import pacl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [FAM_W-1:0]  addr_family;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [PLEN_W-1:0] prefix_len;

    modport source (output valid, req_type, addr_family, addr_hi, addr_lo, prefix_len,
                    input  ready);
    modport sink   (input  valid, req_type, addr_family, addr_hi, addr_lo, prefix_len,
                    output ready);
endinterface

interface pacl_rsp_if
    import pacl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [DEC_W-1:0] decided_by;
    logic             load_error;

    modport source (output valid, accepted, decided_by, load_error, input ready);
    modport sink   (input  valid, accepted, decided_by, load_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/pacl_dp.sv =====
// ============================================================================
// pacl_dp - datapath of the prefix access list filter
// request capture, the two prefix tables with their fill counts, the scan
// read pointer and the masked prefix compare
// ============================================================================
`default_nettype none

module pacl_dp
    import pacl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [FAM_W-1:0]  in_family,
    input  logic [ADDR_W-1:0] in_addr_hi,
    input  logic [ADDR_W-1:0] in_addr_lo,
    input  logic [PLEN_W-1:0] in_prefix_len
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    // captured request
    logic [FAM_W-1:0]  fam_reg;
    logic [ADDR_W-1:0] hi_reg;
    logic [ADDR_W-1:0] lo_reg;
    logic [PLEN_W-1:0] plen_reg;

    entry_t acc_mem [TABLE_DEPTH];
    entry_t rej_mem [TABLE_DEPTH];
    entry_t acc_q_reg;
    entry_t rej_q_reg;

    logic [CNT_W-1:0] acc_used_reg, acc_used_next;
    logic [CNT_W-1:0] rej_used_reg, rej_used_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    tbl_t             tbl_reg, tbl_next;

    entry_t            wr_entry;
    entry_t            cur;
    logic [CNT_W-1:0]  used_sel;
    logic              acc_full;
    logic              rej_full;
    logic              more;
    logic              issue;
    logic [ADDR_W-1:0] mask_hi;
    logic [ADDR_W-1:0] mask_lo;
    logic              match;

    assign acc_full = (acc_used_reg == FULL_CNT);
    assign rej_full = (rej_used_reg == FULL_CNT);

    assign wr_entry = '{fam: fam_reg, plen: sat_plen(fam_reg, plen_reg),
                        hi: hi_reg, lo: lo_reg};

    assign used_sel = (tbl_reg == TBL_REJECT) ? rej_used_reg : acc_used_reg;
    assign more     = (rd_idx_reg < used_sel);
    assign issue    = cmd.scan_step && !cmd.scan_start && more;

    // masked compare of the entry read in the previous cycle
    assign cur     = (tbl_reg == TBL_REJECT) ? rej_q_reg : acc_q_reg;
    assign mask_hi = ~({ADDR_W{1'b1}} >> cur.plen);
    assign mask_lo = (cur.plen > PLEN_W'(ADDR_W))
                   ? ~({ADDR_W{1'b1}} >> (cur.plen - PLEN_W'(ADDR_W)))
                   : '0;
    assign match   = (cur.fam == fam_reg)
                  && (((cur.hi ^ hi_reg) & mask_hi) == '0)
                  && (((cur.lo ^ lo_reg) & mask_lo) == '0);

    assign stat.accept_full = acc_full;
    assign stat.reject_full = rej_full;
    assign stat.hit         = rd_vld_reg && match;
    assign stat.done        = !more && !(rd_vld_reg && match);

    always_comb
    begin
        acc_used_next = acc_used_reg;
        rej_used_next = rej_used_reg;
        rd_idx_next   = rd_idx_reg;
        rd_vld_next   = rd_vld_reg;
        tbl_next      = tbl_reg;

        if (cmd.clear)
        begin
            acc_used_next = '0;
            rej_used_next = '0;
        end
        else if (cmd.write)
        begin
            if (cmd.write_tbl == TBL_ACCEPT && !acc_full)
            begin
                acc_used_next = acc_used_reg + 1'b1;
            end
            if (cmd.write_tbl == TBL_REJECT && !rej_full)
            begin
                rej_used_next = rej_used_reg + 1'b1;
            end
        end

        if (cmd.scan_start)
        begin
            rd_idx_next = '0;
            rd_vld_next = 1'b0;
            tbl_next    = cmd.scan_tbl;
        end
        else if (cmd.scan_step)
        begin
            rd_vld_next = more;
            if (more)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_used_reg <= '0;
            rej_used_reg <= '0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            tbl_reg      <= TBL_ACCEPT;
        end
        else
        begin
            acc_used_reg <= acc_used_next;
            rej_used_reg <= rej_used_next;
            rd_idx_reg   <= rd_idx_next;
            rd_vld_reg   <= rd_vld_next;
            tbl_reg      <= tbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fam_reg  <= in_family;
            hi_reg   <= in_addr_hi;
            lo_reg   <= in_addr_lo;
            plen_reg <= in_prefix_len;
        end
    end

    // table writes at the fill count
    always_ff @(posedge clk)
    begin
        if (cmd.write && cmd.write_tbl == TBL_ACCEPT && !acc_full)
        begin
            acc_mem[acc_used_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (cmd.write && cmd.write_tbl == TBL_REJECT && !rej_full)
        begin
            rej_mem[rej_used_reg[IDX_W-1:0]] <= wr_entry;
        end
    end

    // registered scan reads, one entry a cycle while scan_step is asserted and entries remain
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            acc_q_reg <= acc_mem[rd_idx_reg[IDX_W-1:0]];
            rej_q_reg <= rej_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pacl_ctrl.sv =====
// ============================================================================
// pacl_ctrl - controller of the prefix access list filter
// request sequencing, table scan order, configuration registers and the
// response output register
// ============================================================================
`default_nettype none

module pacl_ctrl
    import pacl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  req_type_t             in_type,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_accepted,
    output logic [DEC_W-1:0]      out_decided_by,
    output logic                  out_load_error,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cmd_t                  cmd,
    input  stat_t                 stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_PUSH
    } state_t;

    state_t           state_reg, state_next;
    req_type_t        type_reg, type_next;
    logic             phase_reg, phase_next;
    logic             rej_first_reg, rej_first_next;
    logic             acc_dflt_reg, acc_dflt_next;
    logic             res_acc_reg, res_acc_next;
    logic [DEC_W-1:0] res_dec_reg, res_dec_next;
    logic             res_err_reg, res_err_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_acc_reg, out_acc_next;
    logic [DEC_W-1:0] out_dec_reg, out_dec_next;
    logic             out_err_reg, out_err_next;

    tbl_t first_tbl;
    tbl_t second_tbl;
    tbl_t cur_tbl;

    assign first_tbl  = rej_first_reg ? TBL_REJECT : TBL_ACCEPT;
    assign second_tbl = rej_first_reg ? TBL_ACCEPT : TBL_REJECT;
    assign cur_tbl    = phase_reg ? second_tbl : first_tbl;

    assign out_valid      = out_valid_reg;
    assign out_accepted   = out_acc_reg;
    assign out_decided_by = out_dec_reg;
    assign out_load_error = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        phase_next     = phase_reg;
        rej_first_next = rej_first_reg;
        acc_dflt_next  = acc_dflt_reg;
        res_acc_next   = res_acc_reg;
        res_dec_next   = res_dec_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_acc_next   = out_acc_reg;
        out_dec_next   = out_dec_reg;
        out_err_next   = out_err_reg;
        in_ready       = 1'b0;
        cmd            = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCAN_ORDER:   rej_first_next = cfg_data[0];
                CFG_DFLT_VERDICT: acc_dflt_next  = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    type_next   = in_type;
                    if (in_type == REQ_CHECK)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_tbl   = first_tbl;
                        phase_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_APPLY:
            begin
                res_acc_next = 1'b0;
                res_dec_next = DEC_DEFAULT;
                res_err_next = 1'b0;
                unique case (type_reg)
                    REQ_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    REQ_ADD_ACCEPT:
                    begin
                        cmd.write_tbl = TBL_ACCEPT;
                        cmd.write     = !stat.accept_full;
                        res_err_next  = stat.accept_full;
                    end
                    REQ_ADD_REJECT:
                    begin
                        cmd.write_tbl = TBL_REJECT;
                        cmd.write     = !stat.reject_full;
                        res_err_next  = stat.reject_full;
                    end
                    REQ_CHECK:
                    begin
                        // checks go through the scan states
                        res_err_next = 1'b0;
                    end
                endcase
                state_next = ST_PUSH;
            end

            ST_SCAN:
            begin
                cmd.scan_tbl = cur_tbl;
                if (stat.hit)
                begin
                    res_acc_next = (cur_tbl == TBL_ACCEPT);
                    res_dec_next = (cur_tbl == TBL_ACCEPT) ? DEC_ACCEPT : DEC_REJECT;
                    res_err_next = 1'b0;
                    state_next   = ST_PUSH;
                end
                else if (stat.done)
                begin
                    if (!phase_reg)
                    begin
                        phase_next     = 1'b1;
                        cmd.scan_start = 1'b1;
                        cmd.scan_tbl   = second_tbl;
                    end
                    else
                    begin
                        res_acc_next = acc_dflt_reg;
                        res_dec_next = DEC_DEFAULT;
                        res_err_next = 1'b0;
                        state_next   = ST_PUSH;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end

            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = res_acc_reg;
                    out_dec_next   = res_dec_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            type_reg      <= REQ_CLEAR;
            phase_reg     <= 1'b0;
            rej_first_reg <= 1'b0;
            acc_dflt_reg  <= 1'b0;
            res_acc_reg   <= 1'b0;
            res_dec_reg   <= DEC_DEFAULT;
            res_err_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_dec_reg   <= DEC_DEFAULT;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            type_reg      <= type_next;
            phase_reg     <= phase_next;
            rej_first_reg <= rej_first_next;
            acc_dflt_reg  <= acc_dflt_next;
            res_acc_reg   <= res_acc_next;
            res_dec_reg   <= res_dec_next;
            res_err_reg   <= res_err_next;
            out_valid_reg <= out_valid_next;
            out_acc_reg   <= out_acc_next;
            out_dec_reg   <= out_dec_next;
            out_err_reg   <= out_err_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prefix_acl_check.sv =====
// ============================================================================
// prefix_acl_check - address prefix access list filter
// keeps an accept table and a reject table of address prefixes, appends
// entries, clears both tables and checks addresses against them
// ============================================================================
//
//  channel   direction  handshake          payload
//  req       in         valid / ready      req_type, addr_family, addr_hi,
//                                          addr_lo, prefix_len
//  rsp       out        valid / ready      accepted, decided_by, load_error
//  cfg       in         cfg_we, no wait    cfg_index, cfg_data
//
//  clear and append pass from idle through the apply and push states to the
//  response register; a check scans the first table then the second, one
//  entry compared a cycle through the single read port of each table memory,
//  and ends at the first hit, or when both tables are exhausted
//  a request is taken whenever the controller is idle, even while the
//  previous response still sits unread in the output register
//  reset clears fill counts and configuration; table contents are not cleared,
//  entries at or above the fill count are never compared
//
`default_nettype none

module prefix_acl_check
    import pacl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pacl_req_if.sink              req,
    pacl_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: request flow, scan order, config and response register
    pacl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_ready       (req.ready),
        .in_type        (req_type_t'(req.req_type)),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_accepted   (rsp.accepted),
        .out_decided_by (rsp.decided_by),
        .out_load_error (rsp.load_error),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .stat           (stat)
    );

    // datapath: prefix tables, fill counts, scan pointer and compare
    pacl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_family     (req.addr_family),
        .in_addr_hi    (req.addr_hi),
        .in_addr_lo    (req.addr_lo),
        .in_prefix_len (req.prefix_len)
    );

endmodule

`default_nettype wire

// ===== rtl/prefix_acl_check_chk.sv =====
// ============================================================================
// prefix_acl_check_chk - port checker of the prefix access list filter
// watches the request and response channels of the top level
// ============================================================================
`default_nettype none

module prefix_acl_check_chk
    import pacl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  logic             rsp_accepted,
    input  logic [DEC_W-1:0] rsp_decided_by,
    input  logic             rsp_load_error
);

    // requests taken but not yet answered
    logic [1:0] pend_reg, pend_next;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (req_fire && !rsp_fire)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!req_fire && rsp_fire)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_accepted, rsp_decided_by, rsp_load_error}))
        else $error("response changed while stalled");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without a pending request");

    a_no_third: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> pend_reg != 2'd2)
        else $error("request taken while two are pending");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_decided_by == DEC_DEFAULT)
            || (rsp_decided_by == DEC_ACCEPT && rsp_accepted && !rsp_load_error)
            || (rsp_decided_by == DEC_REJECT && !rsp_accepted && !rsp_load_error))
        else $error("verdict does not agree with decision source");

    a_load_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_load_error |-> !rsp_accepted && rsp_decided_by == DEC_DEFAULT)
        else $error("append error carries a verdict");

endmodule

bind prefix_acl_check prefix_acl_check_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_accepted   (rsp.accepted),
    .rsp_decided_by (rsp.decided_by),
    .rsp_load_error (rsp.load_error)
);

`default_nettype wire

// ===== sim/tb_prefix_acl_check.sv =====
// ============================================================================
// tb_prefix_acl_check - self-checking bench for the prefix access list filter
// drives clear, append and check requests through the request channel,
// predicts every response from a shadow copy of both prefix tables and the
// two configuration registers, and compares each response field by field
// ============================================================================
`default_nettype none

module tb_prefix_acl_check;
    import pacl_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    // the limit covers ~1300 requests with both sides stalling a quarter of
    // the time, slowest checks included
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 10;

    // one expected response
    typedef struct packed {
        logic             accepted;
        logic [DEC_W-1:0] decided_by;
        logic             load_error;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pacl_req_if req_ch ();
    pacl_rsp_if rsp_ch ();

    prefix_acl_check #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // shadow state of the filter: both tables, fill counts and registers
    // ------------------------------------------------------------------------
    entry_t      accept_tbl [DEPTH];
    entry_t      reject_tbl [DEPTH];
    int unsigned accept_cnt = 0;
    int unsigned reject_cnt = 0;
    logic        rej_first_sh = 1'b0;
    logic        acc_dflt_sh  = 1'b0;

    verdict_t pending_verdicts [$];

    int  err_count    = 0;
    int  cycle_count  = 0;
    int  n_requests   = 0;
    int  n_checks     = 0;
    int  n_by_accept  = 0;
    int  n_by_reject  = 0;
    int  n_by_default = 0;
    int  n_full       = 0;
    bit  gap_free     = 1'b0;

    // address width of each family, used to cap stored prefix lengths
    function automatic logic [PLEN_W-1:0] fam_width_bits(input logic [FAM_W-1:0] fam);
        logic [PLEN_W-1:0] w;
        case (fam)
            FAM_IPV4:  w = 8'd32;
            FAM_IPV6:  w = 8'd128;
            FAM_MAC48: w = 8'd48;
            default:   w = 8'd64;
        endcase
        return w;
    endfunction

    // leading n bits set; n = 0 gives an empty mask, n = 128 a full one
    function automatic logic [127:0] prefix_mask(input logic [PLEN_W-1:0] n);
        return ~({128{1'b1}} >> n);
    endfunction

    function automatic bit table_hit(input tbl_t which, input logic [FAM_W-1:0] fam,
                                     input logic [127:0] addr);
        entry_t      e;
        int unsigned cnt;
        cnt = (which == TBL_ACCEPT) ? accept_cnt : reject_cnt;
        for (int i = 0; i < cnt; i++)
        begin
            e = (which == TBL_ACCEPT) ? accept_tbl[i] : reject_tbl[i];
            if (e.fam == fam && ((({e.hi, e.lo} ^ addr) & prefix_mask(e.plen)) == '0))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // applies one request to the shadow state and returns its response
    function automatic verdict_t acl_verdict(input req_type_t kind,
                                             input logic [FAM_W-1:0] fam,
                                             input logic [127:0] addr,
                                             input logic [PLEN_W-1:0] plen);
        verdict_t          v;
        entry_t            e;
        logic [PLEN_W-1:0] w;
        v = '0;
        case (kind)
            REQ_CLEAR:
            begin
                accept_cnt = 0;
                reject_cnt = 0;
            end
            REQ_ADD_ACCEPT, REQ_ADD_REJECT:
            begin
                w      = fam_width_bits(fam);
                e.fam  = fam;
                e.plen = (plen > w) ? w : plen;
                e.hi   = addr[127:64];
                e.lo   = addr[63:0];
                if (kind == REQ_ADD_ACCEPT)
                begin
                    if (accept_cnt >= DEPTH)
                        v.load_error = 1'b1;
                    else
                    begin
                        accept_tbl[accept_cnt] = e;
                        accept_cnt++;
                    end
                end
                else
                begin
                    if (reject_cnt >= DEPTH)
                        v.load_error = 1'b1;
                    else
                    begin
                        reject_tbl[reject_cnt] = e;
                        reject_cnt++;
                    end
                end
            end
            default:
            begin
                // first match in scan order wins, default register otherwise
                if (rej_first_sh && table_hit(TBL_REJECT, fam, addr))
                    v.decided_by = DEC_REJECT;
                else if (table_hit(TBL_ACCEPT, fam, addr))
                begin
                    v.accepted   = 1'b1;
                    v.decided_by = DEC_ACCEPT;
                end
                else if (!rej_first_sh && table_hit(TBL_REJECT, fam, addr))
                    v.decided_by = DEC_REJECT;
                else
                begin
                    v.accepted   = acc_dflt_sh;
                    v.decided_by = DEC_DEFAULT;
                end
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic bit take_gap();
        return !gap_free && ($urandom_range(0, 99) < 26);
    endfunction

    function automatic logic [127:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // picks a live entry from either table, 0 when both are empty
    function automatic bit pick_entry(output entry_t e);
        bit from_accept;
        e = '0;
        if (accept_cnt == 0 && reject_cnt == 0)
            return 1'b0;
        if (accept_cnt == 0)
            from_accept = 1'b0;
        else if (reject_cnt == 0)
            from_accept = 1'b1;
        else
            from_accept = $urandom_range(0, 1);
        if (from_accept)
            e = accept_tbl[$urandom_range(0, accept_cnt - 1)];
        else
            e = reject_tbl[$urandom_range(0, reject_cnt - 1)];
        return 1'b1;
    endfunction

    // sends one request; called and returning just after a falling edge
    task automatic send_request(input req_type_t kind, input logic [FAM_W-1:0] fam,
                                input logic [127:0] addr, input logic [PLEN_W-1:0] plen);
        verdict_t v;
        while (take_gap())
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.req_type    = kind;
        req_ch.addr_family = fam;
        req_ch.addr_hi     = addr[127:64];
        req_ch.addr_lo     = addr[63:0];
        req_ch.prefix_len  = plen;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // request taken at this edge, predict in acceptance order
        v = acl_verdict(kind, fam, addr, plen);
        pending_verdicts.push_back(v);
        n_requests++;
        if (kind == REQ_CHECK)
        begin
            n_checks++;
            case (v.decided_by)
                DEC_ACCEPT: n_by_accept++;
                DEC_REJECT: n_by_reject++;
                default:    n_by_default++;
            endcase
        end
        if (v.load_error)
            n_full++;
        @(negedge clk);
    endtask

    // every request gives a response, so an empty queue means the block is idle
    task automatic drain_responses();
        req_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == CFG_SCAN_ORDER)
            rej_first_sh = val;
        else
            acc_dflt_sh = val;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty tables after reset: default register alone decides
    task automatic test_empty_tables();
        send_request(REQ_CHECK, FAM_IPV4, '0, 8'd0);
        send_request(REQ_CHECK, FAM_IPV6, {128{1'b1}}, 8'd128);
        send_request(REQ_CHECK, FAM_EUI64, rand_addr(), 8'd64);
        drain_responses();
        write_config(CFG_DFLT_VERDICT, 1'b1);
        send_request(REQ_CHECK, FAM_MAC48, rand_addr(), 8'd17);
    endtask

    // matching rules: prefix compare, ignored low bits, length capping,
    // zero-length prefix, family mismatch and scan order
    task automatic test_prefix_rules();
        logic [127:0] junk;
        junk = rand_addr();
        send_request(REQ_CLEAR, FAM_IPV4, '0, 8'd0);
        send_request(REQ_ADD_ACCEPT, FAM_IPV4, {32'h0A01_0000, 96'd0}, 8'd16);
        send_request(REQ_ADD_REJECT, FAM_IPV4, {32'hC0A8_0001, 96'd0}, 8'd128);
        send_request(REQ_ADD_REJECT, FAM_IPV4, {32'h0A01_0200, 96'd0}, 8'd24);
        send_request(REQ_ADD_ACCEPT, FAM_IPV6, {128{1'b1}}, 8'd128);
        send_request(REQ_ADD_REJECT, FAM_MAC48, junk, 8'd0);
        send_request(REQ_ADD_ACCEPT, FAM_EUI64, {64'h0123_4567_89AB_CDEF, 64'd0}, 8'd100);
        // accept table scanned first
        send_request(REQ_CHECK, FAM_IPV4, {32'h0A01_024D, junk[95:0]}, 8'd0);
        send_request(REQ_CHECK, FAM_IPV4, {32'h0A01_09FF, junk[95:0]}, 8'd7);
        send_request(REQ_CHECK, FAM_IPV4, {32'h0A02_0000, 96'd0}, 8'd0);
        send_request(REQ_CHECK, FAM_IPV4, {32'hC0A8_0001, ~junk[95:0]}, 8'd128);
        send_request(REQ_CHECK, FAM_IPV4, {32'hC0A8_0000, 96'd0}, 8'd0);
        send_request(REQ_CHECK, FAM_IPV6, {128{1'b1}}, 8'd0);
        send_request(REQ_CHECK, FAM_IPV6, {{127{1'b1}}, 1'b0}, 8'd0);
        send_request(REQ_CHECK, FAM_MAC48, rand_addr(), 8'd0);
        // same bits as an ipv4 entry but another family
        send_request(REQ_CHECK, FAM_IPV6, {32'h0A01_024D, 96'd0}, 8'd0);
        send_request(REQ_CHECK, FAM_EUI64, {64'h0123_4567_89AB_CDEF, ~junk[63:0]}, 8'd0);
        drain_responses();
        // reject table first, default reject
        write_config(CFG_SCAN_ORDER, 1'b1);
        write_config(CFG_DFLT_VERDICT, 1'b0);
        send_request(REQ_CHECK, FAM_IPV4, {32'h0A01_024D, junk[95:0]}, 8'd0);
        send_request(REQ_CHECK, FAM_IPV4, {32'h0A01_09FF, 96'd0}, 8'd0);
        send_request(REQ_CHECK, FAM_IPV4, {32'h0A02_0000, 96'd0}, 8'd0);
        send_request(REQ_CHECK, FAM_EUI64, {64'h0123_4567_89AB_CDEE, 64'd0}, 8'd0);
    endtask

    // appends beyond the table depth are refused and flagged
    task automatic test_table_full();
        send_request(REQ_CLEAR, FAM_IPV6, rand_addr(), 8'd0);
        repeat (DEPTH + 1)
            send_request(REQ_ADD_ACCEPT, FAM_W'($urandom_range(0, 3)), rand_addr(),
                         PLEN_W'($urandom_range(0, 128)));
        repeat (DEPTH + 1)
            send_request(REQ_ADD_REJECT, FAM_W'($urandom_range(0, 3)), rand_addr(),
                         PLEN_W'($urandom_range(0, 128)));
        send_request(REQ_CHECK, FAM_W'($urandom_range(0, 3)), rand_addr(), 8'd0);
        send_request(REQ_CLEAR, FAM_IPV4, '0, 8'd0);
        send_request(REQ_CHECK, FAM_W'($urandom_range(0, 3)), rand_addr(), 8'd0);
    endtask

    // one table build followed by checks aimed mostly at stored prefixes
    task automatic random_sequence();
        int                n_acc;
        int                n_rej;
        int                bitpos;
        entry_t            e;
        logic [FAM_W-1:0]  fam;
        logic [127:0]      addr;
        logic [PLEN_W-1:0] plen;
        req_type_t         kind;
        if ($urandom_range(0, 99) < 75)
            send_request(REQ_CLEAR, FAM_W'($urandom_range(0, 3)), rand_addr(),
                         PLEN_W'($urandom_range(0, 128)));
        n_acc = $urandom_range(0, 18);
        n_rej = $urandom_range(0, 18);
        while (n_acc + n_rej > 0)
        begin
            if (n_rej == 0 || (n_acc != 0 && $urandom_range(0, 1)))
            begin
                kind = REQ_ADD_ACCEPT;
                n_acc--;
            end
            else
            begin
                kind = REQ_ADD_REJECT;
                n_rej--;
            end
            // nested prefixes so both tables often cover the same address
            if ($urandom_range(0, 99) < 60 && pick_entry(e))
            begin
                fam  = e.fam;
                addr = {e.hi, e.lo} ^ (rand_addr() & ~prefix_mask(e.plen));
            end
            else
            begin
                fam  = FAM_W'($urandom_range(0, 3));
                addr = rand_addr();
            end
            if ($urandom_range(0, 1))
                plen = PLEN_W'($urandom_range(0, fam_width_bits(fam)));
            else
                plen = PLEN_W'($urandom_range(0, 128));
            send_request(kind, fam, addr, plen);
        end
        repeat ($urandom_range(4, 20))
        begin
            // stray request of any kind
            if ($urandom_range(0, 99) < 5)
                send_request(req_type_t'($urandom_range(0, 3)), FAM_W'($urandom_range(0, 3)),
                             rand_addr(), PLEN_W'($urandom_range(0, 128)));
            if ($urandom_range(0, 99) < 75 && pick_entry(e))
            begin
                fam  = e.fam;
                addr = {e.hi, e.lo} ^ (rand_addr() & ~prefix_mask(e.plen));
                // break the prefix now and then
                if (e.plen != 0 && $urandom_range(0, 99) < 20)
                begin
                    bitpos       = 127 - $urandom_range(0, e.plen - 1);
                    addr[bitpos] = ~addr[bitpos];
                end
                if ($urandom_range(0, 99) < 10)
                    fam = fam + FAM_W'($urandom_range(1, 3));
            end
            else
            begin
                fam  = FAM_W'($urandom_range(0, 3));
                addr = rand_addr();
            end
            send_request(REQ_CHECK, fam, addr, PLEN_W'($urandom_range(0, 128)));
        end
    endtask

    task automatic random_phase(input logic rf, input logic ad, input bit steady);
        int target;
        drain_responses();
        write_config(CFG_SCAN_ORDER, rf);
        write_config(CFG_DFLT_VERDICT, ad);
        gap_free = steady;
        target   = n_requests + PHASE_ITEMS;
        while (n_requests < target)
            random_sequence();
        drain_responses();
        gap_free = 1'b0;
    endtask

    // every register setting, one phase with no stalls on either side
    task automatic test_random_traffic();
        random_phase(1'b0, 1'b0, 1'b0);
        random_phase(1'b1, 1'b1, 1'b0);
        random_phase(1'b0, 1'b1, 1'b1);
        random_phase(1'b1, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // response side: random back-pressure, compare at the rising edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
        rsp_ch.ready = !take_gap();

    always @(posedge clk)
    begin : check_response
        verdict_t exp_v;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("response with no request outstanding: accepted %0b decided_by %0d",
                       rsp_ch.accepted, rsp_ch.decided_by);
                err_count++;
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (rsp_ch.accepted !== exp_v.accepted)
                begin
                    $error("accepted: expected %0b, got %0b", exp_v.accepted,
                           rsp_ch.accepted);
                    err_count++;
                end
                if (rsp_ch.decided_by !== exp_v.decided_by)
                begin
                    $error("decided_by: expected %0d, got %0d", exp_v.decided_by,
                           rsp_ch.decided_by);
                    err_count++;
                end
                if (rsp_ch.load_error !== exp_v.load_error)
                begin
                    $error("load_error: expected %0b, got %0b", exp_v.load_error,
                           rsp_ch.load_error);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                 pending_verdicts.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_CLEAR;
        req_ch.addr_family = FAM_IPV4;
        req_ch.addr_hi     = '0;
        req_ch.addr_lo     = '0;
        req_ch.prefix_len  = '0;
        rsp_ch.ready       = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SCAN_ORDER;
        cfg_data           = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_tables();
        test_prefix_rules();
        test_table_full();
        test_random_traffic();

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d checks: %0d by accept table, %0d by reject table,",
                 n_requests, n_checks, n_by_accept, n_by_reject);
        $display("%0d by default register, %0d appends to a full table, all four settings",
                 n_by_default, n_full);
        if (err_count == 0 && pending_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/pacl_pkg.sv
rtl/pacl_if.sv
rtl/pacl_dp.sv
rtl/pacl_ctrl.sv
rtl/prefix_acl_check.sv
rtl/prefix_acl_check_chk.sv
sim/tb_prefix_acl_check.sv
